// ===== hw/rtl/pott_pkg.sv =====
// ----------------------------------------------------------------------------
// pott_pkg
// Shared types and codes for the priority-ordered task table.
// ----------------------------------------------------------------------------
package pott_pkg;

  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int CMD_W    = 3;
  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 8;

  // command codes on the input word
  localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RUN     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   priority_req;
    logic [SLOT_W-1:0]   slot_id;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   task_slot;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  active_count;
    logic                last;
  } out_item_t;

  // decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_CREATE,
    OP_DESTROY,
    OP_RUN,
    OP_FIND,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic [SLOT_W-1:0]   sid;
    logic                sid_ok;
  } task_cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic      valid;
    task_cmd_t cmd;
  } cmd_slot_t;

endpackage

// ===== hw/rtl/pott_front.sv =====
// ----------------------------------------------------------------------------
// pott_front
// Accepts input words, decodes the command and queues it for the back end.
// ----------------------------------------------------------------------------
module pott_front #(
  parameter int TASK_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pott_pkg::in_item_t  in_data,
  output pott_pkg::cmd_slot_t q_head,
  input  logic                q_pop
);
  import pott_pkg::*;

  task_cmd_t  dec;
  task_cmd_t  q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // decode the command word
  always_comb begin
    dec.handle = in_data.handle;
    dec.prio   = in_data.priority_req;
    dec.sid    = in_data.slot_id;
    dec.sid_ok = (32'(in_data.slot_id) < TASK_SLOTS);
    unique case (in_data.cmd)
      CMD_CREATE:  dec.op = OP_CREATE;
      CMD_DESTROY: dec.op = OP_DESTROY;
      CMD_RUN:     dec.op = OP_RUN;
      CMD_FIND:    dec.op = OP_FIND;
      CMD_CLEAR:   dec.op = OP_CLEAR;
      default:     dec.op = OP_BAD;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  // advance queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = q_r[rd_ptr_r];

endmodule

// ===== hw/rtl/pott_back.sv =====
// ----------------------------------------------------------------------------
// pott_back
// Executes queued commands on the linked task table and drives the results.
// ----------------------------------------------------------------------------
module pott_back #(
  parameter int TASK_SLOTS  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pott_pkg::cmd_slot_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pott_pkg::out_item_t out_data
);
  import pott_pkg::*;

  localparam int IW = $clog2(TASK_SLOTS);
  localparam int LW = IW + 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [LW-1:0] NO_SLOT = LW'(TASK_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FREE, S_WALK_RD, S_WALK_CMP, S_LINK1, S_LINK2,
    S_DEL, S_FIND_RD, S_FIND_CMP, S_RUN_RD, S_RUN_EMIT, S_EMIT
  } state_t;

  // table storage
  logic [HANDLE_BITS-1:0] handle_mem [TASK_SLOTS];
  logic [PRIO_W-1:0]      prio_mem   [TASK_SLOTS];
  logic [LW-1:0]          next_mem   [TASK_SLOTS];
  logic [LW-1:0]          prev_mem   [TASK_SLOTS];
  logic [HANDLE_BITS-1:0] handle_q;
  logic [PRIO_W-1:0]      prio_q;
  logic [LW-1:0]          next_q;
  logic [LW-1:0]          prev_q;

  logic [IW-1:0] rd_addr;
  logic          hp_we;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_addr, pv_addr;
  logic [LW-1:0] nx_data, pv_data;

  state_t                state_r, state_nxt;
  logic [TASK_SLOTS-1:0] active_r, active_nxt;
  logic [LW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;
  task_cmd_t             cmd_r, cmd_nxt;
  logic [LW-1:0]         cur_r, cur_nxt;
  logic [LW-1:0]         before_r, before_nxt;
  logic [IW-1:0]         scan_r, scan_nxt;
  logic [IW-1:0]         new_r, new_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;

  logic          out_free;
  logic [IW-1:0] sid_idx;
  logic [IW-1:0] cur_idx;

  assign out_free = !out_valid_r || !out_stall;
  assign sid_idx  = IW'(cmd_r.sid);
  assign cur_idx  = cur_r[IW-1:0];

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    before_nxt     = before_r;
    scan_nxt       = scan_r;
    new_nxt        = new_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    rd_addr        = cur_idx;
    hp_we          = 1'b0;
    nx_we          = 1'b0;
    pv_we          = 1'b0;
    nx_addr        = new_r;
    pv_addr        = new_r;
    nx_data        = cur_r;
    pv_data        = before_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head.cmd;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_slot_nxt   = '0;
        res_status_nxt = ST_NONE;
        state_nxt      = S_EMIT;
        unique case (cmd_r.op)
          OP_CREATE: begin
            if (count_r == CW'(TASK_SLOTS)) begin
              res_status_nxt = ST_FULL;
            end else begin
              scan_nxt  = '0;
              state_nxt = S_FREE;
            end
          end
          OP_DESTROY: begin
            res_slot_nxt = cmd_r.sid;
            if (cmd_r.sid_ok && active_r[sid_idx]) begin
              rd_addr   = sid_idx;
              state_nxt = S_DEL;
            end
          end
          OP_RUN: begin
            if (head_r != NO_SLOT) begin
              cur_nxt   = head_r;
              state_nxt = S_RUN_RD;
            end
          end
          OP_FIND: begin
            scan_nxt  = '0;
            state_nxt = S_FIND_RD;
          end
          OP_CLEAR: begin
            active_nxt     = '0;
            head_nxt       = NO_SLOT;
            count_nxt      = '0;
            res_status_nxt = ST_OK;
          end
          default: ;
        endcase
      end

      // find the lowest free slot
      S_FREE: begin
        if (!active_r[scan_r]) begin
          new_nxt    = scan_r;
          cur_nxt    = head_r;
          before_nxt = NO_SLOT;
          state_nxt  = S_WALK_RD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      // walk the list to the insertion point
      S_WALK_RD: begin
        state_nxt = (cur_r == NO_SLOT) ? S_LINK1 : S_WALK_CMP;
      end

      S_WALK_CMP: begin
        if (cmd_r.prio < prio_q) begin
          state_nxt = S_LINK1;
        end else begin
          before_nxt = cur_r;
          cur_nxt    = next_q;
          state_nxt  = S_WALK_RD;
        end
      end

      // write the new slot and its own links
      S_LINK1: begin
        hp_we = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (before_r == NO_SLOT) begin
          head_nxt = {1'b0, new_r};
        end
        state_nxt = S_LINK2;
      end

      // patch the neighbors
      S_LINK2: begin
        nx_we   = (before_r != NO_SLOT);
        nx_addr = before_r[IW-1:0];
        nx_data = {1'b0, new_r};
        pv_we   = (cur_r != NO_SLOT);
        pv_addr = cur_idx;
        pv_data = {1'b0, new_r};
        active_nxt[new_r] = 1'b1;
        count_nxt         = count_r + 1'b1;
        res_slot_nxt      = SLOT_W'(new_r);
        res_status_nxt    = ST_OK;
        state_nxt         = S_EMIT;
      end

      // unlink a slot
      S_DEL: begin
        if (prev_q != NO_SLOT) begin
          nx_we   = 1'b1;
          nx_addr = prev_q[IW-1:0];
          nx_data = next_q;
        end else begin
          head_nxt = next_q;
        end
        pv_we   = (next_q != NO_SLOT);
        pv_addr = next_q[IW-1:0];
        pv_data = prev_q;
        active_nxt[sid_idx] = 1'b0;
        count_nxt           = count_r - 1'b1;
        res_status_nxt      = ST_OK;
        state_nxt           = S_EMIT;
      end

      // search handles in slot order
      S_FIND_RD: begin
        rd_addr   = scan_r;
        state_nxt = S_FIND_CMP;
      end

      S_FIND_CMP: begin
        if (active_r[scan_r] && handle_q == HANDLE_BITS'(cmd_r.handle)) begin
          res_slot_nxt   = SLOT_W'(scan_r);
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end else if (scan_r == LAST_IDX) begin
          res_slot_nxt   = '0;
          res_status_nxt = ST_NONE;
          state_nxt      = S_EMIT;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_FIND_RD;
        end
      end

      // emit the run order, one word per entry
      S_RUN_RD: begin
        state_nxt = S_RUN_EMIT;
      end

      S_RUN_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.task_slot    = SLOT_W'(cur_idx);
          out_data_nxt.status       = ST_OK;
          out_data_nxt.active_count = COUNT_W'(count_r);
          out_data_nxt.last         = (next_q == NO_SLOT);
          cur_nxt                   = next_q;
          state_nxt                 = (next_q == NO_SLOT) ? S_IDLE : S_RUN_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.task_slot    = res_slot_r;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.active_count = COUNT_W'(count_r);
          out_data_nxt.last         = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      head_r      <= NO_SLOT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    before_r     <= before_nxt;
    scan_r       <= scan_nxt;
    new_r        <= new_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
  end

  // table memories: one write port each, registered read
  always_ff @(posedge clk) begin
    if (hp_we) begin
      handle_mem[new_r] <= HANDLE_BITS'(cmd_r.handle);
      prio_mem[new_r]   <= cmd_r.prio;
    end
    if (nx_we) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (pv_we) begin
      prev_mem[pv_addr] <= pv_data;
    end
    handle_q <= handle_mem[rd_addr];
    prio_q   <= prio_mem[rd_addr];
    next_q   <= next_mem[rd_addr];
    prev_q   <= prev_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/priority_ordered_task_table_core.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_task_table_core
// Task table kept as one linked list sorted by priority, creation order.
// ----------------------------------------------------------------------------
// Commands enter a two-word queue and run one at a time in the back end.
// A command is dispatched and then does its list or slot walk: create scans
// free slots one per cycle and then walks the list to the insertion point;
// find reads one handle at a time in slot order; run order gives one word
// per list entry, waiting while the output stalls; destroy, clear and
// unknown commands need no walk. The walk rate is set by the registered
// read of the link memory, whose data picks the next address.
// Results leave through an output register, so the queue keeps taking words
// while a result waits, until it holds two words.
module priority_ordered_task_table_core #(
  parameter int TASK_SLOTS  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pott_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pott_pkg::out_item_t out_data
);
  import pott_pkg::*;

  cmd_slot_t q_head;
  logic      q_pop;

  pott_front #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  pott_back #(
    .TASK_SLOTS  (TASK_SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/pott_checker.sv =====
// ----------------------------------------------------------------------------
// pott_checker
// Port-level checks on the task table result channel.
// ----------------------------------------------------------------------------
module pott_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input pott_pkg::out_item_t out_data
);
  import pott_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // drop results at reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a full table reports no slot and ends the command
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |->
      out_data.task_slot == '0 && out_data.last)
    else $error("table full word malformed");

  // only run order gives words that are not last, and those are ok
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK &&
      out_data.active_count != '0)
    else $error("non-final word with bad status");

endmodule

bind priority_ordered_task_table_core pott_checker u_pott_checker (.*);

// ===== bench/priority_ordered_task_table_core_test.sv =====
// ----------------------------------------------------------------------------
// priority_ordered_task_table_core_test
// Drives random and directed task-table commands through the core and checks
// every result word against a priority-sorted linked-list predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_ordered_task_table_core_test;
  import pott_pkg::*;

  localparam int NSLOT = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  priority_ordered_task_table_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state
  bit        tbl_active [NSLOT];
  bit [15:0] tbl_handle [NSLOT];
  bit [7:0]  tbl_prio [NSLOT];
  int        tbl_prev [NSLOT];
  int        tbl_next [NSLOT];
  int        tbl_head;

  in_item_t  pending_words[$];
  out_item_t expected_words[$];
  int        error_count = 0;
  int        hold_off = 0;
  bit        stimulus_done = 1'b0;

  function automatic void table_clear();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_active[i] = 0; tbl_handle[i] = 0; tbl_prio[i] = 8'hFF;
      tbl_prev[i] = NSLOT; tbl_next[i] = NSLOT;
    end
    tbl_head = NSLOT;
  endfunction

  function automatic int active_total();
    int n;
    n = 0;
    for (int i = 0; i < NSLOT; i++) n += tbl_active[i];
    return n;
  endfunction

  function automatic void push_word(int slot, logic [1:0] st, bit lst);
    out_item_t w;
    w.task_slot = slot[3:0];
    w.status = st;
    w.active_count = 5'(active_total());
    w.last = lst;
    expected_words.push_back(w);
  endfunction

  // apply one command to the predictor and queue its result words
  function automatic void predict_command(in_item_t c);
    int cur, prv, s, k;
    s = -1;
    case (c.cmd)
      CMD_CREATE: begin
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && !tbl_active[i]) s = i;
        if (s < 0) push_word(0, ST_FULL, 1);
        else begin
          tbl_handle[s] = c.handle;
          tbl_prio[s] = c.priority_req;
          cur = tbl_head; prv = NSLOT;
          while (cur < NSLOT && tbl_prio[s] >= tbl_prio[cur]) begin
            prv = cur; cur = tbl_next[cur];
          end
          tbl_prev[s] = prv; tbl_next[s] = cur;
          if (prv < NSLOT) tbl_next[prv] = s; else tbl_head = s;
          if (cur < NSLOT) tbl_prev[cur] = s;
          tbl_active[s] = 1;
          push_word(s, ST_OK, 1);
        end
      end
      CMD_DESTROY: begin
        s = c.slot_id;
        if (tbl_active[s]) begin
          tbl_active[s] = 0;
          if (tbl_prev[s] < NSLOT) tbl_next[tbl_prev[s]] = tbl_next[s];
          else tbl_head = tbl_next[s];
          if (tbl_next[s] < NSLOT) tbl_prev[tbl_next[s]] = tbl_prev[s];
          tbl_prev[s] = NSLOT; tbl_next[s] = NSLOT;
          push_word(s, ST_OK, 1);
        end else push_word(s, ST_NONE, 1);
      end
      CMD_RUN: begin
        cur = tbl_head; k = 0;
        if (cur >= NSLOT) push_word(0, ST_NONE, 1);
        while (cur < NSLOT && k < NSLOT) begin
          k++;
          push_word(cur, ST_OK, tbl_next[cur] >= NSLOT || k == NSLOT);
          cur = tbl_next[cur];
        end
      end
      CMD_FIND: begin
        for (int i = 0; i < NSLOT; i++)
          if (s < 0 && tbl_active[i] && tbl_handle[i] == c.handle) s = i;
        if (s < 0) push_word(0, ST_NONE, 1); else push_word(s, ST_OK, 1);
      end
      CMD_CLEAR: begin
        table_clear();
        push_word(0, ST_OK, 1);
      end
      default: push_word(0, ST_NONE, 1);
    endcase
  endfunction

  function automatic in_item_t make_word(logic [2:0] op, logic [15:0] h,
                                         logic [7:0] p, logic [3:0] sid);
    in_item_t w;
    w.cmd = op; w.handle = h; w.priority_req = p; w.slot_id = sid;
    return w;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
         : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // stimulus
  initial begin
    logic [2:0] op;
    // directed: extremes, ties, full table, special cases
    pending_words.push_back(make_word(CMD_RUN, 16'h0, 8'h0, 4'h0));
    pending_words.push_back(make_word(CMD_FIND, 16'h0, 8'h0, 4'h0));
    pending_words.push_back(make_word(CMD_DESTROY, 16'h0, 8'h0, 4'hF));
    for (int i = 0; i < 17; i++)
      pending_words.push_back(make_word(CMD_CREATE, (i == 1) ? 16'hFFFF : i[15:0],
        (i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h80), 4'h0));
    pending_words.push_back(make_word(CMD_RUN, 16'h0, 8'h0, 4'h0));
    pending_words.push_back(make_word(CMD_FIND, 16'hFFFF, 8'hFF, 4'hF));
    pending_words.push_back(make_word(CMD_DESTROY, 16'hFFFF, 8'hFF, 4'h5));
    pending_words.push_back(make_word(3'd5, 16'hFFFF, 8'hFF, 4'hF));
    pending_words.push_back(make_word(3'd7, 16'h0, 8'h0, 4'h0));
    pending_words.push_back(make_word(CMD_CLEAR, 16'h0, 8'h0, 4'h0));
    // random: mostly create/destroy/run, with narrow values for hits and ties
    for (int i = 0; i < 350; i++) begin
      case ($urandom_range(0, 19))
        0,1,2,3,4,5,6: op = CMD_CREATE;
        7,8,9,10,11:   op = CMD_DESTROY;
        12,13,14:      op = CMD_RUN;
        15,16,17:      op = CMD_FIND;
        18:            op = ($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_RUN;
        default:       op = 3'($urandom_range(5, 7));
      endcase
      pending_words.push_back(make_word(op,
        $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom),
        $urandom_range(0, 1) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom),
        4'($urandom)));
    end
    table_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // acceptance seen at the rising edge
  logic in_stall_seen = 1'b1;
  always @(posedge clk) begin
    in_stall_seen <= !(in_valid && !in_stall);
    if (rst_n && in_valid && !in_stall) predict_command(in_data);
  end

  // driver: present words at the falling edge
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_seen) begin
        // accepted at the prior rising edge; advance
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0; stimulus_done <= 1'b1;
        end else if (send_gap == 0) begin
          in_data <= pending_words.pop_front();
          send_gap = short_gap();
        end else begin
          in_valid <= 1'b0; send_gap--;
        end
      end else if (!in_valid) begin
        if (pending_words.size() == 0) stimulus_done <= 1'b1;
        else if (send_gap == 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          send_gap = short_gap();
        end else send_gap--;
      end
    end
  end

  // receiver stall: random gaps, plus one long hold-off to back the block up
  int rx_count = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off--;
        out_stall <= 1'b1;
      end else if (rx_count == 60) begin
        hold_off = 400;
        rx_count++;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (short_gap() > 0);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      rx_count++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word, slot", out_data.task_slot, -1);
      end else begin
        w = expected_words.pop_front();
        if (out_data.task_slot !== w.task_slot)
          report_mismatch("task_slot", out_data.task_slot, w.task_slot);
        if (out_data.status !== w.status)
          report_mismatch("status", out_data.status, w.status);
        if (out_data.active_count !== w.active_count)
          report_mismatch("active_count", out_data.active_count, w.active_count);
        if (out_data.last !== w.last)
          report_mismatch("last", out_data.last, w.last);
      end
    end
  end

  // end of run
  initial begin
    wait (stimulus_done);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== priority_ordered_task_table_core.f =====
hw/rtl/pott_pkg.sv
hw/rtl/pott_front.sv
hw/rtl/pott_back.sv
hw/rtl/priority_ordered_task_table_core.sv
hw/rtl/pott_checker.sv
bench/priority_ordered_task_table_core_test.sv
